/* sv/fir11_filter_with_amplitude_macros.svh */
// assertion macros shared by the fir11 rtl files
// expects clk and arst_n in the scope of the including module
`ifndef FIR11_FILTER_WITH_AMPLITUDE_MACROS_SVH
`define FIR11_FILTER_WITH_AMPLITUDE_MACROS_SVH

// condition must hold in the same cycle
`define FIR11_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition must hold in the next cycle
`define FIR11_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/fir11_pkg.sv */
// shared constants and types of the fir11 filter
// no dependencies
package fir11_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 15;
	localparam int COEF_BITS   = 16;
	// history taps that carry a nonzero coefficient (outer taps are zero)
	localparam int TAP_SPAN    = 9;
	localparam int TAP_PAIRS   = TAP_SPAN / 2;
	localparam int PRE_BITS    = SAMPLE_BITS + 1;
	localparam int PROD_BITS   = PRE_BITS + COEF_BITS;
	localparam int ACC_BITS    = PROD_BITS + 3;
	localparam int AMP_BITS    = SAMPLE_BITS - 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	// q1.15 side taps, pair k weights history k and TAP_SPAN-1-k
	localparam logic signed [COEF_BITS-1:0] TAP_SIDE [TAP_PAIRS] =
		'{-16'sd257, -16'sd1316, -16'sd3385, -16'sd5596};
	localparam logic signed [COEF_BITS-1:0] TAP_MID = 16'sd26230;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] y;
		logic                          last;
	} fir11_item_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} fir11_qstat_t;

endpackage

/* sv/fir11_in_if.sv */
// input sample channel of the fir11 filter
// depends on fir11_pkg
interface fir11_in_if import fir11_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

/* sv/fir11_out_if.sv */
// result channel of the fir11 filter
// depends on fir11_pkg
interface fir11_out_if import fir11_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] filtered;
	logic        [AMP_BITS-1:0]    amplitude;
	logic                          run_end;

	modport source (output valid, output filtered, output amplitude, output run_end,
		input ready);
	modport sink   (input valid, input filtered, input amplitude, input run_end,
		output ready);
endinterface

/* sv/fir11_front.sv */
// front end: delay line, symmetric pre-add, multiply, sum, round and saturate
// depends on fir11_pkg and fir11_in_if
module fir11_front import fir11_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	fir11_in_if.sink      samples,
	input  fir11_qstat_t  qstat,
	output logic          push,
	output fir11_item_t   push_item
);

	localparam logic signed [ACC_BITS-1:0] ROUND_ADD = ACC_BITS'(1 << (FRAC_BITS - 1));
	localparam logic signed [ACC_BITS-1:0] SAT_HI    = ACC_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [ACC_BITS-1:0] SAT_LO    = ACC_BITS'(-(1 << (SAMPLE_BITS - 1)));

	logic signed [SAMPLE_BITS-1:0] hist_q [TAP_SPAN];
	logic                          adv;
	logic                          accept;

	logic                          v_s1, v_s2, v_s3;
	logic                          last_s1, last_s2, last_s3;
	logic signed [PRE_BITS-1:0]    pre_s1 [TAP_PAIRS];
	logic signed [PRE_BITS-1:0]    mid_s1;
	logic signed [PROD_BITS-1:0]   prod_s2 [TAP_PAIRS];
	logic signed [PROD_BITS-1:0]   mprod_s2;
	logic signed [ACC_BITS-1:0]    acc_s3;
	logic signed [ACC_BITS-1:0]    rounded;

	// whole pipe moves together, it only halts when the tail item cannot enter the queue
	assign adv           = !v_s3 || !qstat.full;
	assign samples.ready = adv;
	assign accept        = samples.valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TAP_SPAN; k++) begin
				hist_q[k] <= '0;
			end
		end else if (accept) begin
			hist_q[0] <= samples.sample;
			for (int k = 1; k < TAP_SPAN; k++) begin
				hist_q[k] <= hist_q[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= samples.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// the current sample has a zero tap, only history feeds the sum
			for (int k = 0; k < TAP_PAIRS; k++) begin
				pre_s1[k] <= PRE_BITS'(hist_q[k]) + PRE_BITS'(hist_q[TAP_SPAN-1-k]);
			end
			mid_s1  <= PRE_BITS'(hist_q[TAP_PAIRS]);
			last_s1 <= samples.last_sample;

			for (int k = 0; k < TAP_PAIRS; k++) begin
				prod_s2[k] <= pre_s1[k] * TAP_SIDE[k];
			end
			mprod_s2 <= mid_s1 * TAP_MID;
			last_s2  <= last_s1;

			acc_s3 <= ACC_BITS'(prod_s2[0]) + ACC_BITS'(prod_s2[1])
				+ ACC_BITS'(prod_s2[2]) + ACC_BITS'(prod_s2[3]) + ACC_BITS'(mprod_s2);
			last_s3 <= last_s2;
		end
	end

	assign rounded = (acc_s3 + ROUND_ADD) >>> FRAC_BITS;

	always_comb begin
		if (rounded > SAT_HI) begin
			push_item.y = SAT_HI[SAMPLE_BITS-1:0];
		end else if (rounded < SAT_LO) begin
			push_item.y = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			push_item.y = rounded[SAMPLE_BITS-1:0];
		end
		push_item.last = last_s3;
	end

	assign push = v_s3 && !qstat.full;

endmodule

/* sv/fir11_queue.sv */
// short fifo between the filter front end and the run tracker
// depends on fir11_pkg and the assertion macros
`include "fir11_filter_with_amplitude_macros.svh"
module fir11_queue import fir11_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  fir11_item_t  push_item,
	input  logic         pop,
	output fir11_item_t  pop_item,
	output fir11_qstat_t qstat
);

	fir11_item_t          slot_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// depth is a power of two, pointers wrap on their own
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign pop_item        = slot_q[rd_ptr_q];
	assign qstat.full      = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign qstat.not_empty = (count_q != '0);

	`FIR11_ASSERT_NOW(a_no_push_full, push, count_q != QCNT_BITS'(QUEUE_DEPTH), "push into full queue")
	`FIR11_ASSERT_NOW(a_no_pop_empty, pop, count_q != '0, "pop from empty queue")
	`FIR11_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1, "fill count lost a push")
	`FIR11_ASSERT_NOW(a_count_bound, 1'b1, count_q <= QCNT_BITS'(QUEUE_DEPTH), "fill count overrun")

endmodule

/* sv/fir11_back.sv */
// back end: run min/max tracking, half peak-to-peak and result register
// depends on fir11_pkg, fir11_out_if and the assertion macros
`include "fir11_filter_with_amplitude_macros.svh"
module fir11_back import fir11_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  fir11_qstat_t qstat,
	input  fir11_item_t  pop_item,
	output logic         pop,
	fir11_out_if.source  results
);

	logic signed [SAMPLE_BITS-1:0] min_q, max_q;
	logic                          fresh_q;
	logic                          ovalid_q;
	logic signed [SAMPLE_BITS-1:0] filt_q;
	logic        [AMP_BITS-1:0]    amp_q;
	logic                          end_q;

	logic signed [SAMPLE_BITS-1:0] nmin, nmax;
	logic        [SAMPLE_BITS:0]   spread;

	assign pop = qstat.not_empty && (!ovalid_q || results.ready);

	always_comb begin
		if (fresh_q || pop_item.y < min_q) begin
			nmin = pop_item.y;
		end else begin
			nmin = min_q;
		end
		if (fresh_q || pop_item.y > max_q) begin
			nmax = pop_item.y;
		end else begin
			nmax = max_q;
		end
		spread = (SAMPLE_BITS+1)'(nmax) - (SAMPLE_BITS+1)'(nmin);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q    <= '0;
			max_q    <= '0;
			fresh_q  <= 1'b1;
			ovalid_q <= 1'b0;
		end else if (pop) begin
			min_q    <= nmin;
			max_q    <= nmax;
			fresh_q  <= pop_item.last;
			ovalid_q <= 1'b1;
		end else if (results.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			filt_q <= pop_item.y;
			amp_q  <= spread[SAMPLE_BITS-1:1];
			end_q  <= pop_item.last;
		end
	end

	assign results.valid     = ovalid_q;
	assign results.filtered  = filt_q;
	assign results.amplitude = amp_q;
	assign results.run_end   = end_q;

	`FIR11_ASSERT_NOW(a_min_le_max, !fresh_q, min_q <= max_q, "run min above run max")
	`FIR11_ASSERT_NEXT(a_fresh_follows_last, pop && pop_item.last, fresh_q, "run did not restart after last")

endmodule

/* sv/fir11_filter_with_amplitude.sv */
// top level of the 11-tap symmetric fir filter with run amplitude
// depends on fir11_pkg, fir11_in_if, fir11_out_if, fir11_front, fir11_queue, fir11_back
//
// filters a stream of signed q1.15 samples with a fixed 11-tap symmetric fir
// (taps 0, -257, -1316, -3385, -5596, 26230, mirrored), rounds the sum, shifts
// it right by 15 and saturates it to 16 bits; each result also carries half the
// peak-to-peak spread of the filtered values of the current run, and run_end,
// which copies the last_sample mark of the request; the run restarts after a
// marked request while the delay line keeps running; history before the first
// sample reads as zero; one request is taken every clock as long as results are
// taken, and the input only stalls once the four-entry queue has filled behind a
// stalled result side; a result passes the three-stage pre-add, multiply and sum
// pipe, whose first stage loads on the edge that takes its request, then the
// queue write and the result register
module fir11_filter_with_amplitude import fir11_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	fir11_in_if.sink    samples,
	fir11_out_if.source results
);

	// queue handshake between front and back
	logic         push;
	logic         pop;
	fir11_item_t  push_item;
	fir11_item_t  pop_item;
	fir11_qstat_t qstat;

	// front: delay line and multiply-accumulate pipe, stalls only when the queue is full
	fir11_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.qstat     (qstat),
		.push      (push),
		.push_item (push_item)
	);

	// short fifo so the result side can stall without freezing the filter at once
	fir11_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.qstat     (qstat)
	);

	// back: run min/max tracking and the result register
	fir11_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.pop_item (pop_item),
		.pop      (pop),
		.results  (results)
	);

endmodule

/* tb/fir11_filter_with_amplitude_tb_pkg.sv */
// scoreboard for the fir11 filter testbench: output predictor and expected-result store
// depends on fir11_pkg
`timescale 1ns / 1ps

package fir11_filter_with_amplitude_tb_pkg;
	import fir11_pkg::*;

	localparam int FIR_LEN  = 11;
	localparam int HIST_LEN = FIR_LEN - 1;
	// q1.15 taps, index 0 weights the newest sample
	localparam longint FIR_TAPS [FIR_LEN] =
		'{0, -257, -1316, -3385, -5596, 26230, -5596, -3385, -1316, -257, 0};
	localparam longint Y_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint Y_MIN = -(longint'(1) <<< (SAMPLE_BITS - 1));
	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = Y_MAX[SAMPLE_BITS-1:0];
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = Y_MIN[SAMPLE_BITS-1:0];

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] filtered;
		logic        [AMP_BITS-1:0]    amplitude;
		logic                          run_end;
	} fir_result_t;

	class fir_amplitude_board;
		logic signed [SAMPLE_BITS-1:0] history [HIST_LEN];
		longint      run_lo;
		longint      run_hi;
		bit          run_fresh;
		fir_result_t expected_results [$];
		int          mismatches;
		int          checked;
		int          runs_closed;
		int          clipped;

		function new();
			foreach (history[i])
				history[i] = '0;
			run_lo      = 0;
			run_hi      = 0;
			run_fresh   = 1'b1;
			mismatches  = 0;
			checked     = 0;
			runs_closed = 0;
			clipped     = 0;
		endfunction

		// filter one accepted request and queue the result it must produce
		function void note_sample(logic signed [SAMPLE_BITS-1:0] value, logic mark);
			longint      acc;
			longint      y;
			fir_result_t exp_res;
			acc = FIR_TAPS[0] * longint'(value);
			for (int i = 0; i < HIST_LEN; i++)
				acc += FIR_TAPS[i + 1] * longint'(history[i]);
			y = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
			if (y > Y_MAX || y < Y_MIN)
				clipped++;
			if (y > Y_MAX)
				y = Y_MAX;
			if (y < Y_MIN)
				y = Y_MIN;
			for (int i = HIST_LEN - 1; i > 0; i--)
				history[i] = history[i - 1];
			history[0] = value;
			if (run_fresh) begin
				run_lo = y;
				run_hi = y;
			end else begin
				if (y < run_lo)
					run_lo = y;
				if (y > run_hi)
					run_hi = y;
			end
			run_fresh = mark;
			exp_res.filtered  = y[SAMPLE_BITS-1:0];
			exp_res.amplitude = AMP_BITS'((run_hi - run_lo) >>> 1);
			exp_res.run_end   = mark;
			expected_results.push_back(exp_res);
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		function void check_output(logic signed [SAMPLE_BITS-1:0] filtered,
			logic [AMP_BITS-1:0] amplitude, logic run_end);
			fir_result_t exp_res;
			if (expected_results.size() == 0) begin
				$display("%0t unexpected result: filtered %0d amplitude %0d run_end %0b",
					$time, filtered, amplitude, run_end);
				mismatches++;
				return;
			end
			exp_res = expected_results.pop_front();
			checked++;
			if (run_end === 1'b1)
				runs_closed++;
			if (filtered !== exp_res.filtered) begin
				$display("%0t filtered mismatch: expected %0d actual %0d",
					$time, exp_res.filtered, filtered);
				mismatches++;
			end
			if (amplitude !== exp_res.amplitude) begin
				$display("%0t amplitude mismatch: expected %0d actual %0d",
					$time, exp_res.amplitude, amplitude);
				mismatches++;
			end
			if (run_end !== exp_res.run_end) begin
				$display("%0t run_end mismatch: expected %0b actual %0b",
					$time, exp_res.run_end, run_end);
				mismatches++;
			end
		endfunction
	endclass

endpackage

/* tb/fir11_filter_with_amplitude_tb.sv */
// testbench top of the fir11 filter: drives sample requests, stalls the result side
// and checks every result; depends on fir11_pkg, the fir11 interfaces and the tb package
`timescale 1ns / 1ps

module fir11_filter_with_amplitude_tb;
	import fir11_pkg::*;
	import fir11_filter_with_amplitude_tb_pkg::*;

	localparam int ITEM_TOTAL   = 1750;
	localparam int GAP_MAX      = 19;
	// idle cycles with no request moving on either side before giving up
	localparam int STALL_LIMIT  = 500;
	// margin after the drain for stray results
	localparam int DRAIN_CYCLES = 12;

	// content style of one random run
	typedef enum int {
		SHAPE_NOISE,
		SHAPE_QUIET,
		SHAPE_RAIL,
		SHAPE_TOGGLE
	} sample_shape_e;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	fir11_in_if  samples_ch ();
	fir11_out_if results_ch ();

	fir11_filter_with_amplitude i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.results (results_ch)
	);

	fir_amplitude_board board = new();

	int requests_sent = 0;
	int idle_cycles   = 0;
	bit rush_source   = 1'b0;
	bit rush_sink     = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// monitor: values read right after the edge are the ones the block saw
	// results are checked before the new request is noted, so a result can
	// never be matched against a request taken in the same cycle
	always @(posedge clk) begin
		if (arst_n === 1'b1 && results_ch.valid === 1'b1 && results_ch.ready === 1'b1)
			board.check_output(results_ch.filtered, results_ch.amplitude,
				results_ch.run_end);
		if (arst_n === 1'b1 && samples_ch.valid === 1'b1 && samples_ch.ready === 1'b1)
			board.note_sample(samples_ch.sample, samples_ch.last_sample);
		if ((samples_ch.valid === 1'b1 && samples_ch.ready === 1'b1) ||
			(results_ch.valid === 1'b1 && results_ch.ready === 1'b1))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// watchdog: a hung handshake ends the run
	initial begin
		wait (idle_cycles >= STALL_LIMIT);
		$display("%0t no request moved for %0d cycles, %0d results outstanding",
			$time, STALL_LIMIT, board.pending());
		$display("TB_ERROR");
		$finish;
	end

	// one sample request; valid stays high across back-to-back requests so it
	// only gets a single assignment per edge
	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value,
		input logic mark);
		int gap;
		gap = rush_source ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			samples_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples_ch.valid       <= 1'b1;
		samples_ch.sample      <= value;
		samples_ch.last_sample <= mark;
		do
			@(posedge clk);
		while (samples_ch.ready !== 1'b1);
		requests_sent++;
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(sample_shape_e shape,
		int pos);
		int quiet;
		quiet = int'($urandom_range(0, 1023)) - 512;
		case (shape)
			SHAPE_QUIET: begin
				return SAMPLE_BITS'(quiet);
			end
			SHAPE_RAIL: begin
				return ($urandom_range(0, 1) == 1) ? S_MAX : S_MIN;
			end
			// alternating rails drive the filter output past its clip level
			SHAPE_TOGGLE: begin
				return (pos % 2 == 1) ? S_MAX : S_MIN;
			end
			default: begin
				return SAMPLE_BITS'($urandom);
			end
		endcase
	endfunction

	// result side: random stall before each result, with stretches of none
	initial begin
		int stall;
		int taken;
		taken = 0;
		results_ch.ready <= 1'b0;
		forever begin
			if (taken % 80 == 0)
				rush_sink = ($urandom_range(0, 3) == 0);
			stall = rush_sink ? 0 : $urandom_range(0, GAP_MAX);
			if (stall > 0) begin
				results_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			results_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (results_ch.valid !== 1'b1);
			taken++;
		end
	end

	initial begin
		int            roll;
		int            run_len;
		sample_shape_e shape;
		samples_ch.valid       <= 1'b0;
		samples_ch.sample      <= '0;
		samples_ch.last_sample <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: zero history at start, one-request runs back to back,
		// then a window built to clip the output high and then low
		send_sample('0, 1'b1);
		send_sample(S_MAX, 1'b1);
		send_sample(S_MIN, 1'b0);
		// center tap on the positive rail, all side taps on the negative one
		for (int j = 0; j < HIST_LEN; j++)
			send_sample((j == 5) ? S_MAX : S_MIN, 1'b0);
		// first request here sees the high clip, the one after the loop the low clip
		for (int j = 0; j < HIST_LEN; j++)
			send_sample((j == 5) ? S_MIN : S_MAX, j == 0);
		send_sample('0, 1'b1);

		// random runs of random length, each ended by a marked request
		while (requests_sent < ITEM_TOTAL) begin
			roll = $urandom_range(0, 9);
			if (roll < 4)
				shape = SHAPE_NOISE;
			else if (roll < 6)
				shape = SHAPE_QUIET;
			else if (roll < 8)
				shape = SHAPE_RAIL;
			else
				shape = SHAPE_TOGGLE;
			run_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 40);
			for (int pos = 0; pos < run_len; pos++) begin
				if (requests_sent % 128 == 0)
					rush_source = ($urandom_range(0, 3) == 0);
				send_sample(pick_sample(shape, pos), pos == run_len - 1);
			end
		end
		samples_ch.valid <= 1'b0;

		// drain, then give stray results a chance to show up
		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d sample requests, checked %0d results over %0d closed runs",
			requests_sent, board.checked, board.runs_closed);
		$display("%0d outputs clipped to the rails, %0d mismatches",
			board.clipped, board.mismatches);
		if (board.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
